>>> hw/rtl/ofc_pkg.sv
// ============================================================================
// ofc_pkg
// Shared types and constants for the object flag combiner.
// ============================================================================
package ofc_pkg;

    // Fixed field widths of the external beats
    localparam int FLAG_W  = 32;
    localparam int COUNT_W = 16;
    localparam int MODE_W  = 3;

    // combine_mode register codes
    localparam logic [MODE_W-1:0] MODE_OR   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AND  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MAX  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MOST = 3'd4;

    // Input beat: one object pixel
    typedef struct packed {
        logic [FLAG_W-1:0] flag_value;
        logic              last_pixel;
    } in_beat_t;

    // Output beat: one object result
    typedef struct packed {
        logic [FLAG_W-1:0]  combined_flag;
        logic [COUNT_W-1:0] match_count;
        logic               table_overflow;
    } out_beat_t;

    // Accumulate operation decided by the front end
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_OR   = 3'd1,
        OP_AND  = 3'd2,
        OP_MIN  = 3'd3,
        OP_MAX  = 3'd4,
        OP_MOST = 3'd5
    } op_t;

    // Which state forms the result at the last pixel
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_RUN   = 2'd1,
        RES_TABLE = 2'd2
    } res_t;

    // Control part of a queued item
    typedef struct packed {
        op_t  op;
        res_t res;
        logic last;
    } item_ctl_t;

    // Saturating count increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
    endfunction

endpackage

>>> hw/rtl/ofc_ram.sv
// ============================================================================
// ofc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ofc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ofc_queue.sv
// ============================================================================
// ofc_queue
// Two-entry FIFO between the classifier and the execution engine.
// ============================================================================
module ofc_queue #(
    parameter int DATA_W = 38
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/ofc_front.sv
// ============================================================================
// ofc_front
// Holds the mode register and classifies each accepted pixel beat.
// ============================================================================
module ofc_front #(
    parameter int FLAG_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ofc_pkg::MODE_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ofc_pkg::in_beat_t                s_data,
    output logic                             item_valid,
    input  logic                             item_ready,
    output ofc_pkg::item_ctl_t               item_ctl,
    output logic [FLAG_BITS-1:0]             item_value
);

    logic [ofc_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [FLAG_BITS-1:0]       value;

    // Mode register, always writable
    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ofc_pkg::MODE_OR;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // Only the low FLAG_BITS bits count
    assign value      = s_data.flag_value[FLAG_BITS-1:0];
    assign item_value = value;
    assign item_valid = s_valid;
    assign s_ready    = item_ready;

    // Classify: operation under the current mode, zero values do nothing
    always_comb begin
        item_ctl.last = s_data.last_pixel;
        item_ctl.op   = ofc_pkg::OP_NONE;
        item_ctl.res  = ofc_pkg::RES_ZERO;
        unique case (mode_reg) inside
            ofc_pkg::MODE_OR, ofc_pkg::MODE_AND,
            ofc_pkg::MODE_MIN, ofc_pkg::MODE_MAX: item_ctl.res = ofc_pkg::RES_RUN;
            ofc_pkg::MODE_MOST:                   item_ctl.res = ofc_pkg::RES_TABLE;
            default:                              item_ctl.res = ofc_pkg::RES_ZERO;
        endcase
        if (value != '0) begin
            unique case (mode_reg)
                ofc_pkg::MODE_OR:   item_ctl.op = ofc_pkg::OP_OR;
                ofc_pkg::MODE_AND:  item_ctl.op = ofc_pkg::OP_AND;
                ofc_pkg::MODE_MIN:  item_ctl.op = ofc_pkg::OP_MIN;
                ofc_pkg::MODE_MAX:  item_ctl.op = ofc_pkg::OP_MAX;
                ofc_pkg::MODE_MOST: item_ctl.op = ofc_pkg::OP_MOST;
                default:            item_ctl.op = ofc_pkg::OP_NONE;
            endcase
        end
    end

endmodule

>>> hw/rtl/ofc_back.sv
// ============================================================================
// ofc_back
// Execution engine: running accumulators, distinct-value table search and
// result register.
// ============================================================================
module ofc_back #(
    parameter int TABLE_DEPTH = 16,
    parameter int FLAG_BITS   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ofc_pkg::item_ctl_t   q_ctl,
    input  logic [FLAG_BITS-1:0] q_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ofc_pkg::out_beat_t   m_data
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_W = ofc_pkg::COUNT_W;
    localparam int FLAG_W  = ofc_pkg::FLAG_W;
    localparam int ENTRY_W = FLAG_BITS + COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [FLAG_BITS-1:0] run_flag_reg, run_flag_next;
    logic [COUNT_W-1:0]   run_cnt_reg, run_cnt_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 ovf_reg, ovf_next;
    logic [FLAG_BITS-1:0] best_val_reg, best_val_next;
    logic [COUNT_W-1:0]   best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [FLAG_BITS-1:0] cur_val_reg, cur_val_next;
    logic                 cur_last_reg, cur_last_next;
    ofc_pkg::res_t        cur_res_reg, cur_res_next;
    logic                 m_valid_reg, m_valid_next;
    ofc_pkg::out_beat_t   m_data_reg, m_data_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [FLAG_BITS-1:0] rd_val;
    logic [COUNT_W-1:0]   rd_cnt, inc_cnt;

    logic                 do_insert;
    logic [FLAG_BITS-1:0] ins_val;
    logic                 table_room;
    logic                 out_free;
    state_t               done_state;

    // Table entries: value in the upper bits, count in the lower
    ofc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val     = ram_rdata[COUNT_W +: FLAG_BITS];
    assign rd_cnt     = ram_rdata[COUNT_W-1:0];
    assign inc_cnt    = ofc_pkg::sat_inc(rd_cnt);
    assign ins_val    = (state_reg == ST_IDLE) ? q_value : cur_val_reg;
    assign table_room = (fill_reg < FILL_W'(TABLE_DEPTH));
    assign out_free   = !m_valid_reg || m_ready;
    assign q_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Engine control and datapath
    always_comb begin
        state_next    = state_reg;
        run_flag_next = run_flag_reg;
        run_cnt_next  = run_cnt_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        best_val_next = best_val_reg;
        best_cnt_next = best_cnt_reg;
        best_idx_next = best_idx_reg;
        k_next        = k_reg;
        cur_val_next  = cur_val_reg;
        cur_last_next = cur_last_reg;
        cur_res_next  = cur_res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = k_reg;
        ram_wdata     = {rd_val, inc_cnt};
        ram_raddr     = '0;
        do_insert     = 1'b0;
        done_state    = cur_last_reg ? ST_EMIT : ST_IDLE;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cur_val_next  = q_value;
                    cur_last_next = q_ctl.last;
                    cur_res_next  = q_ctl.res;
                    state_next    = q_ctl.last ? ST_EMIT : ST_IDLE;
                    case (q_ctl.op)
                        ofc_pkg::OP_OR: begin
                            run_flag_next = run_flag_reg | q_value;
                            run_cnt_next  = ofc_pkg::sat_inc(run_cnt_reg);
                        end
                        ofc_pkg::OP_AND: begin
                            run_flag_next = (run_cnt_reg == '0) ? q_value
                                                                : (run_flag_reg & q_value);
                            run_cnt_next  = ofc_pkg::sat_inc(run_cnt_reg);
                        end
                        ofc_pkg::OP_MIN: begin
                            if (run_cnt_reg == '0 || q_value < run_flag_reg) begin
                                run_flag_next = q_value;
                                run_cnt_next  = COUNT_W'(1);
                            end else if (q_value == run_flag_reg) begin
                                run_cnt_next  = ofc_pkg::sat_inc(run_cnt_reg);
                            end
                        end
                        ofc_pkg::OP_MAX: begin
                            if (run_cnt_reg == '0 || q_value > run_flag_reg) begin
                                run_flag_next = q_value;
                                run_cnt_next  = COUNT_W'(1);
                            end else if (q_value == run_flag_reg) begin
                                run_cnt_next  = ofc_pkg::sat_inc(run_cnt_reg);
                            end
                        end
                        ofc_pkg::OP_MOST: begin
                            if (fill_reg == '0) begin
                                do_insert = 1'b1;
                            end else begin
                                // scan starts at entry 0
                                k_next     = '0;
                                ram_raddr  = '0;
                                state_next = ST_SEARCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SEARCH: begin
                // read data holds entry k_reg
                if (rd_val == cur_val_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = k_reg;
                    ram_wdata = {rd_val, inc_cnt};
                    if (inc_cnt > best_cnt_reg ||
                        (inc_cnt == best_cnt_reg && k_reg < best_idx_reg)) begin
                        best_val_next = rd_val;
                        best_cnt_next = inc_cnt;
                        best_idx_next = k_reg;
                    end
                    state_next = done_state;
                end else if (FILL_W'(k_reg) + FILL_W'(1) == fill_reg) begin
                    do_insert  = 1'b1;
                    state_next = done_state;
                end else begin
                    k_next    = k_reg + IDX_W'(1);
                    ram_raddr = k_reg + IDX_W'(1);
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    case (cur_res_reg)
                        ofc_pkg::RES_RUN: begin
                            if (run_cnt_reg != '0) begin
                                m_data_next.combined_flag = FLAG_W'(run_flag_reg);
                                m_data_next.match_count   = run_cnt_reg;
                            end
                        end
                        ofc_pkg::RES_TABLE: begin
                            // empty table gives a zero flag
                            if (best_cnt_reg != '0) begin
                                m_data_next.combined_flag = FLAG_W'(best_val_reg);
                                m_data_next.match_count   = best_cnt_reg;
                            end
                            m_data_next.table_overflow = ovf_reg;
                        end
                        default: ;
                    endcase
                    // clear object state
                    run_flag_next = '0;
                    run_cnt_next  = '0;
                    fill_next     = '0;
                    ovf_next      = 1'b0;
                    best_cnt_next = '0;
                    best_idx_next = '0;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // New distinct value goes to the next free entry
        if (do_insert) begin
            if (table_room) begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg[IDX_W-1:0];
                ram_wdata = {ins_val, COUNT_W'(1)};
                fill_next = fill_reg + FILL_W'(1);
                if (best_cnt_reg == '0) begin
                    best_val_next = ins_val;
                    best_cnt_next = COUNT_W'(1);
                    best_idx_next = fill_reg[IDX_W-1:0];
                end
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            run_flag_reg <= '0;
            run_cnt_reg  <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            best_cnt_reg <= '0;
            best_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            run_flag_reg <= run_flag_next;
            run_cnt_reg  <= run_cnt_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            best_cnt_reg <= best_cnt_next;
            best_idx_reg <= best_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        best_val_reg <= best_val_next;
        k_reg        <= k_next;
        cur_val_reg  <= cur_val_next;
        cur_last_reg <= cur_last_next;
        cur_res_reg  <= cur_res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

>>> hw/rtl/object_flag_combiner.sv
// ============================================================================
// object_flag_combiner
// Combines the flag values of one object's pixels into one result beat.
// ============================================================================
//
//  Channel   Ports                               Beat
//  --------  ----------------------------------  ------------------------------
//  config    cfg_valid / cfg_ready / cfg_data    combine_mode (3 bits)
//  pixels    s_valid / s_ready / s_data          flag_value, last_pixel
//  results   m_valid / m_ready / m_data          combined_flag, match_count,
//                                                table_overflow
//
//  OR, AND, MIN, MAX and zero-valued pixels update the running state straight
//  from the queue. A most-frequent pixel goes to an empty table at once, else
//  scans the distinct-value table, which sits in a RAM with one read port,
//  one entry per cycle until a match or the last entry held.
//  A last pixel then passes through the emit state to load the result
//  register, and waits there while the previous result still waits on m_ready.
//  A two-beat queue decouples the pixel input from the engine; the result
//  register lets the engine go on while a result waits on m_ready.
//  Reset (aresetn low, synchronous) clears mode to OR and all object state.
//
module object_flag_combiner #(
    parameter int TABLE_DEPTH = 16,
    parameter int FLAG_BITS   = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ofc_pkg::MODE_W-1:0] cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ofc_pkg::in_beat_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ofc_pkg::out_beat_t         m_data
);

    localparam int CTL_W  = $bits(ofc_pkg::item_ctl_t);
    localparam int ITEM_W = CTL_W + FLAG_BITS;

    logic                 fe_valid, fe_ready;
    ofc_pkg::item_ctl_t   fe_ctl;
    logic [FLAG_BITS-1:0] fe_value;
    logic                 be_valid, be_ready;
    logic [ITEM_W-1:0]    be_item;
    ofc_pkg::item_ctl_t   be_ctl;
    logic [FLAG_BITS-1:0] be_value;

    // Front: mode register and classification
    ofc_front #(
        .FLAG_BITS (FLAG_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (fe_valid),
        .item_ready (fe_ready),
        .item_ctl   (fe_ctl),
        .item_value (fe_value)
    );

    // Queue between front and engine
    ofc_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  ({fe_ctl, fe_value}),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_data   (be_item)
    );

    assign be_ctl   = ofc_pkg::item_ctl_t'(be_item[FLAG_BITS +: CTL_W]);
    assign be_value = be_item[FLAG_BITS-1:0];

    // Engine
    ofc_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FLAG_BITS   (FLAG_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (be_valid),
        .q_ready (be_ready),
        .q_ctl   (be_ctl),
        .q_value (be_value),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> test/tb_object_flag_combiner.sv
// ============================================================================
// tb_object_flag_combiner
// Self-checking bench for the object flag combiner. A behavioral predictor
// tracks every mode, the distinct-value table and the saturating counts, and
// each result beat is compared field by field against it. Directed objects
// cover the mode rules and corner cases, then a full table hits overflow,
// and a long result stall backs up the input; a random phase mixes modes,
// object sizes, mode changes inside open objects and idling on both sides.
// ============================================================================
module tb_object_flag_combiner;

    localparam int FLAG_W  = ofc_pkg::FLAG_W;
    localparam int COUNT_W = ofc_pkg::COUNT_W;
    localparam int MODE_W  = ofc_pkg::MODE_W;

    localparam int TABLE_DEPTH = 16;

    // Codes the mode register accepts but no rule uses
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    localparam int ENGINE_SETTLE  = 64;        // queued and running table scans plus margin
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 3000000;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int POOL_MAX       = 20;
    localparam int REPORT_MAX     = 20;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [MODE_W-1:0]  cfg_data;
    logic               s_valid;
    logic               s_ready;
    ofc_pkg::in_beat_t  s_data;
    logic               m_valid;
    logic               m_ready;
    ofc_pkg::out_beat_t m_data;

    object_flag_combiner #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .FLAG_BITS  (FLAG_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Predictor state: mode, running accumulators and distinct-value table
    logic [MODE_W-1:0]  mode_q;
    logic [FLAG_W-1:0]  run_flag;
    logic [COUNT_W-1:0] run_count;
    logic [FLAG_W-1:0]  tbl_val [TABLE_DEPTH];
    logic [COUNT_W-1:0] tbl_cnt [TABLE_DEPTH];
    int                 tbl_fill;
    logic               tbl_ovf;

    ofc_pkg::out_beat_t object_results_due[$];

    int  fail_count   = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    int  rx_hold_req  = 0;
    bit  idle_on      = 1'b1;

    logic [FLAG_W-1:0]  value_pool [POOL_MAX];
    int                 pool_size = 1;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_object_flag_combiner failed");
            $finish;
        end
    end

    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
        return (c == COUNT_SAT) ? c : c + COUNT_W'(1);
    endfunction

    function automatic void clear_object();
        run_flag  = '0;
        run_count = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            tbl_val[k] = '0;
            tbl_cnt[k] = '0;
        end
        tbl_fill = 0;
        tbl_ovf  = 1'b0;
    endfunction

    // Fold one accepted pixel into the object; a last pixel queues its result
    function automatic void take_pixel(input ofc_pkg::in_beat_t px);
        logic [FLAG_W-1:0]  v;
        ofc_pkg::out_beat_t res;
        bit                 hit;
        v = px.flag_value;
        if (v != '0) begin
            case (mode_q)
                ofc_pkg::MODE_OR: begin
                    run_flag  = run_flag | v;
                    run_count = count_up(run_count);
                end
                ofc_pkg::MODE_AND: begin
                    // first nonzero pixel seeds the AND
                    run_flag  = (run_count == '0) ? v : (run_flag & v);
                    run_count = count_up(run_count);
                end
                ofc_pkg::MODE_MIN: begin
                    if (run_count == '0 || v < run_flag) begin
                        run_flag  = v;
                        run_count = COUNT_W'(1);
                    end else if (v == run_flag) begin
                        run_count = count_up(run_count);
                    end
                end
                ofc_pkg::MODE_MAX: begin
                    if (run_count == '0 || v > run_flag) begin
                        run_flag  = v;
                        run_count = COUNT_W'(1);
                    end else if (v == run_flag) begin
                        run_count = count_up(run_count);
                    end
                end
                ofc_pkg::MODE_MOST: begin
                    hit = 1'b0;
                    for (int k = 0; k < tbl_fill; k++) begin
                        if (!hit && tbl_val[k] == v) begin
                            tbl_cnt[k] = count_up(tbl_cnt[k]);
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        if (tbl_fill < TABLE_DEPTH) begin
                            tbl_val[tbl_fill] = v;
                            tbl_cnt[tbl_fill] = COUNT_W'(1);
                            tbl_fill++;
                        end else begin
                            tbl_ovf = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (!px.last_pixel) return;

        res = '0;
        if (mode_q == ofc_pkg::MODE_MOST) begin
            // strict compare keeps the earliest entry on ties
            for (int k = 0; k < tbl_fill; k++) begin
                if (tbl_cnt[k] > res.match_count) begin
                    res.match_count   = tbl_cnt[k];
                    res.combined_flag = tbl_val[k];
                end
            end
            res.table_overflow = tbl_ovf;
        end else if (mode_q <= ofc_pkg::MODE_MAX && run_count != '0) begin
            res.combined_flag = run_flag;
            res.match_count   = run_count;
        end
        object_results_due.push_back(res);
        clear_object();
    endfunction

    function automatic int draw_gap();
        if (!idle_on || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [FLAG_W-1:0] pick_flag();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
            3: return $urandom;
            default: return value_pool[$urandom_range(0, pool_size - 1)];
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [FLAG_W-1:0] got,
                                   input logic [FLAG_W-1:0] want);
        if (fail_count < REPORT_MAX)
            $display("result %0d: %s got %h, expected %h", results_seen, field, got, want);
        fail_count++;
    endtask

    // Result receiver: per-beat idle gaps, plus a long hold on request
    initial begin : result_receiver
        int gap_left;
        int hold_left;
        int hold_seen;
        gap_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seen != rx_hold_req) begin
                hold_seen = rx_hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                gap_left = draw_gap();
                m_ready <= (gap_left == 0);
            end else if (gap_left != 0) begin
                gap_left--;
                m_ready <= (gap_left == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin : check_results
        ofc_pkg::out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (object_results_due.size() == 0) begin
                report_mismatch("beat with no result due", m_data.combined_flag, '0);
            end else begin
                want = object_results_due.pop_front();
                if (m_data.combined_flag !== want.combined_flag)
                    report_mismatch("combined_flag", m_data.combined_flag, want.combined_flag);
                if (m_data.match_count !== want.match_count)
                    report_mismatch("match_count", FLAG_W'(m_data.match_count),
                                    FLAG_W'(want.match_count));
                if (m_data.table_overflow !== want.table_overflow)
                    report_mismatch("table_overflow", FLAG_W'(m_data.table_overflow),
                                    FLAG_W'(want.table_overflow));
            end
            results_seen++;
        end
    end

    // Send one pixel beat; returns at the edge that accepted it
    task automatic send_pixel(input logic [FLAG_W-1:0] flag, input logic last);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {flag, last};
        do @(posedge aclk); while (!s_ready);
        take_pixel({flag, last});
    endtask

    // Stop offering pixels until every due result is back and the engine is quiet
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (object_results_due.size() != 0) @(posedge aclk);
        repeat (ENGINE_SETTLE) @(posedge aclk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] mode);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        mode_q = mode;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // OR from the reset mode, an all-zero object, AND seeded by first nonzero
    task automatic test_or_and();
        send_pixel(32'h0000_0001, 1'b0);
        send_pixel(32'h8000_0000, 1'b1);
        send_pixel('0, 1'b1);
        set_mode(ofc_pkg::MODE_AND);
        send_pixel('0, 1'b0);
        send_pixel(32'hF0F0_FFFF, 1'b0);
        send_pixel(32'hFFFF_0F0F, 1'b1);
    endtask

    task automatic test_min_max();
        set_mode(ofc_pkg::MODE_MIN);
        send_pixel(32'd3, 1'b0);
        send_pixel('1, 1'b0);
        send_pixel(32'd3, 1'b1);
        set_mode(ofc_pkg::MODE_MAX);
        send_pixel('1, 1'b0);
        send_pixel(32'd1, 1'b0);
        send_pixel('1, 1'b1);
    endtask

    // Equal counts go to the value that entered the table first
    task automatic test_most_ties();
        set_mode(ofc_pkg::MODE_MOST);
        send_pixel(32'd9, 1'b0);
        send_pixel(32'd4, 1'b0);
        send_pixel(32'd4, 1'b0);
        send_pixel(32'd9, 1'b1);
        send_pixel('0, 1'b1);
    endtask

    task automatic test_unused_modes();
        set_mode(MODE_UNUSED_HI);
        send_pixel('1, 1'b0);
        send_pixel(32'd5, 1'b1);
        set_mode(MODE_UNUSED_LO);
        send_pixel(32'h1234_5678, 1'b1);
    endtask

    // Mode written while an object is open: no clearing, last pixel's mode rules
    task automatic test_mode_switch_mid_object();
        set_mode(ofc_pkg::MODE_MOST);
        send_pixel(32'd6, 1'b0);
        set_mode(ofc_pkg::MODE_MAX);
        send_pixel(32'd2, 1'b1);
        send_pixel(32'd8, 1'b0);
        set_mode(ofc_pkg::MODE_MOST);
        send_pixel(32'd8, 1'b1);
    endtask

    // One more distinct value than the table holds, a repeat of the one that did not fit, then a held one
    task automatic test_table_full();
        set_mode(ofc_pkg::MODE_MOST);
        for (int k = 1; k <= TABLE_DEPTH + 1; k++) send_pixel(FLAG_W'(k), 1'b0);
        send_pixel(FLAG_W'(TABLE_DEPTH + 1), 1'b0);
        send_pixel(32'd3, 1'b1);
    endtask

    // Receiver holds off long while pixels keep coming, so the input stalls
    task automatic test_backpressure();
        idle_on = 1'b0;
        set_mode(ofc_pkg::MODE_MIN);
        rx_hold_req <= rx_hold_req + 1;
        repeat (40) begin
            send_pixel($urandom, 1'b0);
            send_pixel($urandom, 1'b1);
        end
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_objects();
        int                items_sent;
        int                obj_len;
        bit                obj_open;
        logic [MODE_W-1:0] next_mode;
        items_sent = 0;
        obj_open   = 1'b0;
        while (items_sent < RANDOM_ITEMS) begin
            // new phase: fresh value pool, idling on or off, new mode
            idle_on   = ($urandom_range(0, 3) != 0);
            pool_size = $urandom_range(2, POOL_MAX);
            for (int k = 0; k < POOL_MAX; k++) value_pool[k] = $urandom;
            if ($urandom_range(0, 9) == 0)
                next_mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            else
                next_mode = MODE_W'($urandom_range(ofc_pkg::MODE_OR, ofc_pkg::MODE_MOST));
            set_mode(next_mode);
            repeat ($urandom_range(3, 12)) begin
                obj_len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 28)
                                                      : $urandom_range(1, 8);
                for (int k = 0; k < obj_len; k++) begin
                    send_pixel(pick_flag(), k == obj_len - 1);
                    items_sent++;
                end
            end
            // sometimes leave an object open across the next mode write
            obj_open = ($urandom_range(0, 3) == 0);
            if (obj_open) begin
                repeat ($urandom_range(1, 5)) begin
                    send_pixel(pick_flag(), 1'b0);
                    items_sent++;
                end
            end
        end
        if (obj_open) send_pixel(pick_flag(), 1'b1);
        wait_drain();
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= ofc_pkg::MODE_OR;
        s_valid   <= 1'b0;
        s_data    <= '0;
        mode_q = ofc_pkg::MODE_OR;
        clear_object();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_or_and();
        test_min_max();
        test_most_ties();
        test_unused_modes();
        test_mode_switch_mid_object();
        test_table_full();
        test_backpressure();
        test_random_objects();

        wait_drain();
        if (fail_count == 0) begin
            $display("tb_object_flag_combiner passed");
        end else begin
            $display("tb_object_flag_combiner failed");
        end
        $finish;
    end

endmodule

>>> object_flag_combiner.f
hw/rtl/ofc_pkg.sv
hw/rtl/ofc_ram.sv
hw/rtl/ofc_queue.sv
hw/rtl/ofc_front.sv
hw/rtl/ofc_back.sv
hw/rtl/object_flag_combiner.sv
test/tb_object_flag_combiner.sv
